FILE: rtl/gmcn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid menu cursor navigator package
// Shared types, codes and constants for the navigator controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package gmcn_pkg;

   // Table geometry
   localparam int PRIMARY_MAX   = 16;
   localparam int SECONDARY_MAX = 16;
   localparam int STORE_DEPTH   = PRIMARY_MAX * SECONDARY_MAX;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   // Field widths
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 5;
   localparam int STYLE_W = 3;
   localparam int OP_W    = 4;
   localparam int WORD_W  = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_STYLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PCOUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCOUNT = 2'd2;

   // Configuration reset values
   localparam logic [CNT_W-1:0] PCOUNT_RESET = 5'd16;
   localparam logic [CNT_W-1:0] SCOUNT_RESET = 5'd1;
   localparam logic [CNT_W-1:0] PCOUNT_MAX   = 5'd16;
   localparam logic [CNT_W-1:0] SCOUNT_MAX   = 5'd16;

   // Cell attribute masks
   localparam logic [WORD_W-1:0] SEL_HI_MASK = 32'hF000_0000;
   localparam logic [WORD_W-1:0] SEL_LO_MASK = 32'h0F00_0000;
   localparam logic [WORD_W-1:0] CELL_RESET  = 32'hFF00_0000;

   typedef enum logic [OP_W-1:0] {
      OP_UP         = 4'd0,
      OP_DOWN       = 4'd1,
      OP_LEFT       = 4'd2,
      OP_RIGHT      = 4'd3,
      OP_SET_CURSOR = 4'd4,
      OP_WRITE_CELL = 4'd5,
      OP_WRITE_CUR  = 4'd6,
      OP_READ_CELL  = 4'd7,
      OP_READ_CUR   = 4'd8
   } op_code_type;

   typedef enum logic [STYLE_W-1:0] {
      STYLE_H    = 3'd0,
      STYLE_V    = 3'd1,
      STYLE_HL   = 3'd2,
      STYLE_VL   = 3'd3,
      STYLE_GRID = 3'd4
   } style_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_MOVE,
      KIND_SET,
      KIND_WRITE,
      KIND_READ
   } op_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_ISSUE,
      ST_SCAN_CHECK,
      ST_READ_WAIT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [IDX_W-1:0]  primary_index;
      logic [IDX_W-1:0]  secondary_index;
      logic [WORD_W-1:0] attribute_word;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  cursor_primary;
      logic [IDX_W-1:0]  cursor_secondary;
      logic [WORD_W-1:0] read_attribute;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_init;
      logic scan_step;
      logic scan_land;
      logic set_cursor;
      logic mem_write;
      logic mem_read;
      logic read_capture;
      logic rsp_load;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_kind_type kind;
      logic        scan_end;
      logic        scan_hit;
   } dp_status_type;

endpackage

FILE: rtl/gmcn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid menu cursor navigator controller
// Sequences decode, the cell scan of a move, table accesses and the response.
// ----------------------------------------------------------------------------
module gmcn_ctrl
   import gmcn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output logic          busy,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.kind)
               KIND_MOVE: state_in = ST_SCAN_ISSUE;
               KIND_READ: state_in = ST_READ_WAIT;
               default:   state_in = ST_RESPOND;
            endcase
         end
         ST_SCAN_ISSUE: begin
            state_in = status.scan_end ? ST_RESPOND : ST_SCAN_CHECK;
         end
         ST_SCAN_CHECK: begin
            state_in = status.scan_hit ? ST_RESPOND : ST_SCAN_ISSUE;
         end
         ST_READ_WAIT: state_in = ST_RESPOND;
         ST_RESPOND:   state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_req = start;
         end
         ST_DECODE: begin
            case (status.kind)
               KIND_MOVE:  cmd.scan_init  = 1'b1;
               KIND_SET:   cmd.set_cursor = 1'b1;
               KIND_WRITE: cmd.mem_write  = 1'b1;
               KIND_READ:  cmd.mem_read   = 1'b1;
               default:    cmd = '0;
            endcase
         end
         ST_SCAN_ISSUE: begin
            cmd.scan_step = !status.scan_end;
         end
         ST_SCAN_CHECK: begin
            cmd.scan_land = status.scan_hit;
         end
         ST_READ_WAIT: cmd.read_capture = 1'b1;
         ST_RESPOND:   cmd.rsp_load     = 1'b1;
         default:      cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/gmcn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid menu cursor navigator datapath
// Configuration registers, cursor, scan counter, attribute table and the
// response register.
// ----------------------------------------------------------------------------
module gmcn_datapath
   import gmcn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   logic [STYLE_W-1:0] style_ff;
   logic [CNT_W-1:0]   pcount_ff;
   logic [CNT_W-1:0]   scount_ff;

   req_type            req_ff;
   logic [WORD_W-1:0]  rd_word_ff;
   logic [IDX_W-1:0]   cursor_p_ff;
   logic [IDX_W-1:0]   cursor_s_ff;

   logic               axis_pri_ff;
   logic               fwd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   fix_ff;
   logic               cand_ok_ff;

   logic [WORD_W-1:0]      mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff;
   logic [WORD_W-1:0]      rdata_ff;
   logic                   rvalid_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [CNT_W-1:0]   eff_pc;
   logic [CNT_W-1:0]   eff_sc;
   logic [IDX_W-1:0]   last_p;
   logic [IDX_W-1:0]   last_s;
   logic [IDX_W-1:0]   pi_c;
   logic [IDX_W-1:0]   si_c;
   logic [IDX_W-1:0]   cp_c;
   logic [IDX_W-1:0]   cs_c;

   op_kind_type        kind;
   logic               move_pri;
   logic               move_fwd;

   logic [IDX_W-1:0]   scan_last;
   logic [IDX_W-1:0]   idx_next;
   logic [IDX_W-1:0]   cand_p;
   logic [IDX_W-1:0]   cand_s;
   logic               cand_ok;

   logic               use_req_idx;
   logic [IDX_W-1:0]   addr_p;
   logic [IDX_W-1:0]   addr_s;
   logic [8:0]         slot_full;
   logic [ADDR_W-1:0]  mem_addr;
   logic [WORD_W-1:0]  cell_word;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff  <= STYLE_H;
         pcount_ff <= PCOUNT_RESET;
         scount_ff <= SCOUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STYLE:  style_ff  <= csr_wdata[STYLE_W-1:0];
            CSR_PCOUNT: pcount_ff <= csr_wdata;
            CSR_SCOUNT: scount_ff <= csr_wdata;
            default:    style_ff  <= style_ff;
         endcase
      end
   end

   // Effective counts: zero acts as one, large values saturate; styles H and V use one secondary
   always_comb begin
      if (pcount_ff == '0) begin
         eff_pc = 5'd1;
      end else if (pcount_ff > PCOUNT_MAX) begin
         eff_pc = PCOUNT_MAX;
      end else begin
         eff_pc = pcount_ff;
      end

      if (style_ff inside {STYLE_H, STYLE_V}) begin
         eff_sc = 5'd1;
      end else if (scount_ff == '0) begin
         eff_sc = 5'd1;
      end else if (scount_ff > SCOUNT_MAX) begin
         eff_sc = SCOUNT_MAX;
      end else begin
         eff_sc = scount_ff;
      end
   end

   assign last_p = IDX_W'(eff_pc - 5'd1);
   assign last_s = IDX_W'(eff_sc - 5'd1);

   // Index clamps
   assign pi_c = ({1'b0, req_ff.primary_index} < eff_pc) ? req_ff.primary_index : last_p;
   assign si_c = ({1'b0, req_ff.secondary_index} < eff_sc) ? req_ff.secondary_index : last_s;
   assign cp_c = ({1'b0, cursor_p_ff} < eff_pc) ? cursor_p_ff : last_p;
   assign cs_c = ({1'b0, cursor_s_ff} < eff_sc) ? cursor_s_ff : last_s;

   // Operation decode and move-to-axis mapping
   always_comb begin
      kind     = KIND_NONE;
      move_pri = 1'b0;
      move_fwd = 1'b0;
      case (req_ff.operation)
         OP_UP, OP_DOWN: begin
            move_fwd = (req_ff.operation == OP_DOWN);
            if (style_ff inside {STYLE_V, STYLE_VL, STYLE_GRID}) begin
               kind     = KIND_MOVE;
               move_pri = 1'b1;
            end else if (style_ff == STYLE_HL) begin
               kind = KIND_MOVE;
            end
         end
         OP_LEFT, OP_RIGHT: begin
            move_fwd = (req_ff.operation == OP_RIGHT);
            if (style_ff inside {STYLE_H, STYLE_HL}) begin
               kind     = KIND_MOVE;
               move_pri = 1'b1;
            end else if (style_ff inside {STYLE_VL, STYLE_GRID}) begin
               kind = KIND_MOVE;
            end
         end
         OP_SET_CURSOR:              kind = KIND_SET;
         OP_WRITE_CELL, OP_WRITE_CUR: kind = KIND_WRITE;
         OP_READ_CELL, OP_READ_CUR:   kind = KIND_READ;
         default:                    kind = KIND_NONE;
      endcase
   end

   // Scan step: next candidate along the active axis
   assign scan_last = axis_pri_ff ? last_p : last_s;
   assign idx_next  = fwd_ff ? (idx_ff + 4'd1) : (idx_ff - 4'd1);
   assign cand_p    = axis_pri_ff ? idx_next : fix_ff;
   assign cand_s    = axis_pri_ff ? fix_ff : idx_next;
   assign cand_ok   = ({1'b0, cand_p} < eff_pc) && ({1'b0, cand_s} < eff_sc);

   assign status.kind     = kind;
   assign status.scan_end = fwd_ff ? (idx_ff >= scan_last) : (idx_ff == '0);
   assign status.scan_hit = cand_ok_ff && ((cell_word & SEL_HI_MASK) != '0)
                            && ((cell_word & SEL_LO_MASK) != '0);

   // Table address: cell = p * S + s
   assign use_req_idx = (req_ff.operation == OP_WRITE_CELL)
                        || (req_ff.operation == OP_READ_CELL);
   assign addr_p    = cmd.scan_step ? cand_p : (use_req_idx ? pi_c : cp_c);
   assign addr_s    = cmd.scan_step ? cand_s : (use_req_idx ? si_c : cs_c);
   assign slot_full = ({5'd0, addr_p} * {4'd0, eff_sc}) + {5'd0, addr_s};
   assign mem_addr  = slot_full[ADDR_W-1:0];

   // Attribute table
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[mem_addr] <= req_ff.attribute_word;
      end
      if (cmd.mem_read || cmd.scan_step) begin
         rdata_ff  <= mem[mem_addr];
         rvalid_ff <= valid_ff[mem_addr];
      end
   end

   // Written marks; an unwritten cell reads as the reset attribute
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.mem_write) begin
         valid_ff[mem_addr] <= 1'b1;
      end
   end

   assign cell_word = rvalid_ff ? rdata_ff : CELL_RESET;

   // Request capture and read result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_req) begin
         rd_word_ff <= '0;
      end else if (cmd.read_capture) begin
         rd_word_ff <= cell_word;
      end
   end

   // Scan registers
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         axis_pri_ff <= move_pri;
         fwd_ff      <= move_fwd;
         idx_ff      <= move_pri ? cursor_p_ff : cursor_s_ff;
         if (move_pri) begin
            fix_ff <= (style_ff == STYLE_GRID) ? cursor_s_ff : '0;
         end else begin
            fix_ff <= cursor_p_ff;
         end
      end else if (cmd.scan_step) begin
         idx_ff     <= idx_next;
         cand_ok_ff <= cand_ok;
      end
   end

   // Cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_p_ff <= '0;
         cursor_s_ff <= '0;
      end else if (cmd.set_cursor) begin
         cursor_p_ff <= pi_c;
         cursor_s_ff <= si_c;
      end else if (cmd.scan_land) begin
         if (axis_pri_ff) begin
            cursor_p_ff <= idx_ff;
            cursor_s_ff <= fix_ff;
         end else begin
            cursor_s_ff <= idx_ff;
         end
      end
   end

   // Response register and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.cursor_primary   <= cursor_p_ff;
         rsp_ff.cursor_secondary <= cursor_s_ff;
         rsp_ff.read_attribute   <= rd_word_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/grid_menu_cursor_navigator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid menu cursor navigator
// Cursor over a 16 x 16 table of cell attributes with scanning moves.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until the result has been registered, and the result appears with a
// one-cycle rsp_valid strobe that cannot be held off, so the receiver must
// take it in that cycle. A move scans the cells along its axis one by one,
// each with one table read and then the selectable check, and stops on the
// first selectable cell or at the end of its row or column. The table is one
// single-port memory with a written mark per cell, so it is usable right
// after reset. Configuration writes are taken at any edge with csr_wr_en
// high and are meant for idle periods only.
// ----------------------------------------------------------------------------
module grid_menu_cursor_navigator
   import gmcn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   gmcn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   gmcn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // An accepted command makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // A result strobe is a single cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // The result is shown only once the block has gone idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // A table scan step is only issued while a move is in progress
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step || cmd.scan_land) |-> busy)
      else $error("scan command while idle");

endmodule
